### rtl/per_client_token_bucket_limiter_unit_assert.svh
// ----------------------------------------------------------------------------
// Token bucket limiter assertion macros
// Helpers for the concurrent checks in the limiter RTL.
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_UNIT_ASSERT_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTBL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTBL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// ptbl_pkg
// Constants, register indexes and controller/datapath interface types for
// the per-client token bucket limiter.
// ----------------------------------------------------------------------------
package ptbl_pkg;

	// Default parameter values.
	localparam int NUM_CLIENTS_DEF = 256;
	localparam int TIME_BITS_DEF   = 48;

	// Fixed field widths.
	localparam int IDX_BITS   = 8;
	localparam int NOW_BITS   = 48;
	localparam int CAP_W      = 16;
	localparam int RATE_W     = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_REFILL   = 2'd1;

	// Register reset values.
	localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd3;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd1;

	// Refill arithmetic. Elapsed seconds saturate at SAT_SECS, so only
	// differences below SAT_SECS * 1000 ms need the divider.
	localparam int MS_PER_SEC = 1000;
	localparam int SAT_SECS   = 65536;
	localparam int SAT_MS     = SAT_SECS * MS_PER_SEC;
	localparam int REM_W      = $clog2(SAT_MS);
	localparam int QUOT_W     = $clog2(SAT_SECS);
	localparam int SECS_W     = QUOT_W + 1;
	localparam int PROD_W     = SECS_W + RATE_W;
	localparam int SUM_W      = PROD_W + 1;

	// Seconds from milliseconds by reciprocal multiplication. For every value
	// below 2**REM_W, (ms * DIV_RECIP) >> DIV_SHIFT equals ms / 1000, since
	// DIV_RECIP * 1000 exceeds 2**DIV_SHIFT by only 264.
	localparam int                 RECIP_W   = 27;
	localparam int                 DIV_SHIFT = 36;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
	localparam int                 RPROD_W   = REM_W + RECIP_W;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic prep;
		logic recip;
		logic mul;
		logic sum;
		logic commit;
	} ptbl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic no_refill;
		logic sat;
	} ptbl_status_t;

endpackage

### rtl/per_client_token_bucket_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter_unit
// Token bucket rate limiter with one bucket per client index.
// ----------------------------------------------------------------------------
// Each request beat names a client and the current time in milliseconds and
// returns one beat with permitted set when a token was taken. A client's first
// request creates its bucket full; later requests refill by whole elapsed
// seconds times the refill rate, clamped to the capacity. One request is in
// work at a time: its result is written into the output register straight
// after the lookup when no refill is due, after the multiply and sum when the
// gap is 65536 s or more, and after the divide, multiply and sum when a refill
// needs the seconds count, which one reciprocal multiply by 1/1000 produces.
// The result waits while the output register holds a beat not yet taken. The
// next request can be accepted in the cycle after the previous result is
// written into the output register, even if that beat has not been taken yet.
// Bucket valid flags are cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_client_token_bucket_limiter_unit
	import ptbl_pkg::*;
#(
	parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IDX_BITS-1:0]   client_index,
	input  logic [NOW_BITS-1:0]   now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  permitted
);

	ptbl_cmd_t    cmd;
	ptbl_status_t status;

	// Sequencer.
	ptbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Tables and arithmetic.
	ptbl_dp #(
		.NUM_CLIENTS (NUM_CLIENTS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.client_index (client_index),
		.now_ms       (now_ms),
		.cmd          (cmd),
		.status       (status),
		.permitted    (permitted)
	);

endmodule

### rtl/ptbl_ctrl.sv
// ----------------------------------------------------------------------------
// ptbl_ctrl
// Limiter sequencer: lookup, optional divide, multiply and saturating sum
// when refilling, write-back, plus the output beat register's valid flag.
// ----------------------------------------------------------------------------
`include "per_client_token_bucket_limiter_unit_assert.svh"

module ptbl_ctrl
	import ptbl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  ptbl_status_t status,
	output ptbl_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DIV,
		S_MUL,
		S_SUM,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result can be written once the output register is empty or drains now.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.prep    = (state_q == S_LOOK);
		cmd.recip   = (state_q == S_DIV);
		cmd.mul     = (state_q == S_MUL);
		cmd.sum     = (state_q == S_SUM);
		cmd.commit  = (state_q == S_DONE) && out_free;
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (status.no_refill) begin
						state_q <= S_DONE;
					end else if (status.sat) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result is never written over a beat that is still waiting.
	`PTBL_ASSERT_NOW(a_commit_free, clk, arst_n, cmd.commit, (!out_valid_q || out_ready), "commit over pending beat")
	// Every commit presents a beat in the next cycle.
	`PTBL_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid_q, "commit without output beat")
	// The divide cycle hands over to the multiply.
	`PTBL_ASSERT_NEXT(a_div_end, clk, arst_n, (state_q == S_DIV), (state_q == S_MUL), "divide did not finish")
	// An accepted request always goes to the table lookup.
	`PTBL_ASSERT_NEXT(a_accept_look, clk, arst_n, (in_valid && in_ready), (state_q == S_LOOK && !in_ready), "accept without lookup")

endmodule

### rtl/ptbl_dp.sv
// ----------------------------------------------------------------------------
// ptbl_dp
// Limiter datapath: configuration registers, per-client bucket tables,
// reciprocal seconds divider, refill multiply and saturating sum.
// ----------------------------------------------------------------------------
module ptbl_dp
	import ptbl_pkg::*;
#(
	parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IDX_BITS-1:0]   client_index,
	input  logic [NOW_BITS-1:0]   now_ms,
	input  ptbl_cmd_t             cmd,
	output ptbl_status_t          status,
	output logic                  permitted
);

	// Only 256 clients are reachable through the index field.
	localparam int DEPTH = (NUM_CLIENTS < (1 << IDX_BITS)) ? NUM_CLIENTS : (1 << IDX_BITS);
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [TIME_BITS-1:0] SAT_LIM  = TIME_BITS'(SAT_MS);
	localparam logic [TIME_BITS-1:0] ONE_SEC  = TIME_BITS'(MS_PER_SEC);

	// Configuration registers.
	logic [CAP_W-1:0]  cap_q;
	logic [RATE_W-1:0] rate_q;

	// Bucket tables.
	logic [CAP_W-1:0]     tok_mem  [DEPTH];
	logic [TIME_BITS-1:0] time_mem [DEPTH];
	logic [DEPTH-1:0]     valid_q;

	// Request and lookup registers.
	logic [IDX_W-1:0]     idx_q;
	logic                 in_range_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CAP_W-1:0]     tok_rd_q;
	logic [TIME_BITS-1:0] time_rd_q;
	logic                 vld_rd_q;

	// Working registers.
	logic [CAP_W-1:0]     tok_cur_q;
	logic [TIME_BITS-1:0] time_cur_q;
	logic [REM_W-1:0]     rem_q;
	logic [QUOT_W-1:0]    quot_q;
	logic                 sat_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 permitted_q;

	logic [IDX_W-1:0]              rd_idx;
	logic                          rd_in_range;
	logic [TIME_BITS+NOW_BITS-1:0] now_wide;
	logic [TIME_BITS-1:0]          now_t;
	logic [TIME_BITS-1:0]          diff;
	logic                          backwards;
	logic                          is_new;
	logic [RPROD_W-1:0]            rprod;
	logic [SECS_W-1:0]             secs;
	logic [PROD_W-1:0]             prod_c;
	logic [SUM_W-1:0]              total;
	logic                          permit;

	// Request decode: index into the table and time folded to the stored width.
	assign rd_idx      = client_index[IDX_W-1:0];
	assign rd_in_range = (32'(client_index) < 32'(NUM_CLIENTS));
	assign now_wide    = {{TIME_BITS{1'b0}}, now_ms};
	assign now_t       = now_wide[TIME_BITS-1:0];

	// Elapsed-time classification after the lookup.
	assign diff             = now_q - time_rd_q;
	assign backwards        = (now_q < time_rd_q);
	assign is_new           = !vld_rd_q;
	assign status.no_refill = !in_range_q || is_new || backwards || (diff < ONE_SEC);
	assign status.sat       = (diff >= SAT_LIM);

	// Arithmetic for divide, multiply and saturating sum.
	assign rprod  = rem_q * DIV_RECIP;
	assign secs   = {sat_q, quot_q};
	assign prod_c = secs * rate_q;
	assign total  = SUM_W'(tok_cur_q) + SUM_W'(prod_q);
	assign permit = in_range_q && (tok_cur_q != '0);

	assign permitted = permitted_q;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPACITY: cap_q  <= cfg_data[CAP_W-1:0];
				CFG_REFILL:   rate_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Bucket valid flags, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && in_range_q) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	// Table write-back and registered lookup.
	always_ff @(posedge clk) begin
		if (cmd.commit && in_range_q) begin
			tok_mem[idx_q]  <= tok_cur_q - CAP_W'(permit);
			time_mem[idx_q] <= time_cur_q;
		end
		if (cmd.capture) begin
			tok_rd_q   <= tok_mem[rd_idx];
			time_rd_q  <= time_mem[rd_idx];
			vld_rd_q   <= valid_q[rd_idx];
			idx_q      <= rd_idx;
			in_range_q <= rd_in_range;
			now_q      <= now_t;
		end
	end

	// Refill computation: new bucket setup, divide by 1000 through one
	// reciprocal multiply, multiply by the rate, then add and clamp to capacity.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			tok_cur_q  <= is_new ? cap_q : tok_rd_q;
			time_cur_q <= is_new ? now_q : time_rd_q;
			rem_q      <= diff[REM_W-1:0];
			quot_q     <= '0;
			sat_q      <= status.sat;
		end
		if (cmd.recip) begin
			quot_q <= rprod[DIV_SHIFT +: QUOT_W];
		end
		if (cmd.mul) begin
			prod_q <= prod_c;
		end
		if (cmd.sum) begin
			tok_cur_q  <= (total > SUM_W'(cap_q)) ? cap_q : total[CAP_W-1:0];
			time_cur_q <= now_q;
		end
		if (cmd.commit) begin
			permitted_q <= permit;
		end
	end

endmodule

### bench/tb_per_client_token_bucket_limiter_unit.sv
// ----------------------------------------------------------------------------
// tb_per_client_token_bucket_limiter_unit
// Self-checking bench for the per-client token bucket limiter. A driver feeds
// request beats from a queue, a monitor predicts each permit decision from its
// own bucket table, and every response beat is checked against the oldest
// prediction under several capacity/refill settings and traffic patterns.
// ----------------------------------------------------------------------------
module tb_per_client_token_bucket_limiter_unit
	import ptbl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BUCKETS    = 256;
	localparam int SETTLE_CYCLES  = 30;
	localparam int BACKLOG_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NUM_PHASES     = 10;
	localparam int PHASE_ITEMS    = 170;
	localparam int REQ_DEPTH      = 4096;

	// Register slots the block does not implement; writes there are dropped.
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic [2:0] {
		TR_STEADY,
		TR_SRC_IDLE,
		TR_SINK_STALL,
		TR_BOTH_IDLE,
		TR_BACKLOG
	} traffic_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] client;
		logic [NOW_BITS-1:0] stamp_ms;
	} request_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [IDX_BITS-1:0]   client_index = '0;
	logic [NOW_BITS-1:0]   now_ms       = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic                  permitted;

	// Bench-side copy of the bucket table and the two registers.
	logic                  bucket_live   [NUM_BUCKETS];
	logic [CAP_W-1:0]      bucket_tokens [NUM_BUCKETS];
	logic [NOW_BITS-1:0]   bucket_stamp  [NUM_BUCKETS];
	logic [CAP_W-1:0]      cap_reg;
	logic [RATE_W-1:0]     rate_reg;

	// Pending requests and expected permits, each a ring with head and tail.
	request_t              pending_requests [REQ_DEPTH];
	logic                  expected_permits [REQ_DEPTH];
	int                    req_head      = 0;
	int                    req_tail      = 0;
	int                    exp_head      = 0;
	int                    exp_tail      = 0;
	traffic_t              traffic    = TR_STEADY;
	logic                  in_taken   = 1'b0;
	int                    backlog_count = 0;
	int                    idle_cycles   = 0;
	int                    fail_count    = 0;

	logic [CAP_W-1:0]  phase_cap  [NUM_PHASES] = '{16'd3, 16'd0, 16'd65535, 16'd1, 16'd5,
		16'd2, 16'd65535, 16'd8, 16'd1, 16'd4};
	logic [RATE_W-1:0] phase_rate [NUM_PHASES] = '{16'd1, 16'd7, 16'd65535, 16'd0, 16'd2,
		16'd1, 16'd1, 16'd65535, 16'd3, 16'd0};

	per_client_token_bucket_limiter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.client_index (client_index),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.permitted    (permitted)
	);

	always #5 clk = ~clk;

	// Refill the client's bucket by whole elapsed seconds, then try to take a
	// token. Returns the permit decision and updates the bench bucket table.
	function automatic logic take_token(input logic [IDX_BITS-1:0] cl,
			input logic [NOW_BITS-1:0] t);
		logic [63:0] secs;
		logic [63:0] fill;
		if (!bucket_live[cl]) begin
			bucket_live[cl]   = 1'b1;
			bucket_tokens[cl] = cap_reg;
			bucket_stamp[cl]  = t;
		end else if (t >= bucket_stamp[cl]) begin
			secs = 64'(t - bucket_stamp[cl]) / 64'(MS_PER_SEC);
			if (secs != 0) begin
				if (secs > 64'(SAT_SECS))
					secs = 64'(SAT_SECS);
				fill = 64'(bucket_tokens[cl]) + secs * 64'(rate_reg);
				if (fill > 64'(cap_reg))
					fill = 64'(cap_reg);
				bucket_tokens[cl] = fill[CAP_W-1:0];
				bucket_stamp[cl]  = t;
			end
		end
		if (bucket_tokens[cl] != 0) begin
			bucket_tokens[cl] = bucket_tokens[cl] - 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic queue_request(input logic [IDX_BITS-1:0] cl, input logic [NOW_BITS-1:0] t);
		request_t req;
		req.client   = cl;
		req.stamp_ms = t;
		pending_requests[req_tail % REQ_DEPTH] = req;
		req_tail = req_tail + 1;
	endtask

	// Wait until every request has been sent and answered, then let the
	// block drain its pipeline before anything else happens.
	task automatic wait_idle();
		while (req_head != req_tail || in_valid || exp_head != exp_tail)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_CAPACITY: cap_reg  = val;
			CFG_REFILL:   rate_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver: holds a beat until it is taken, then offers the next
	// one unless the source is idling this cycle.
	always @(negedge clk) begin : drive_requests
		request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (req_head != req_tail &&
				!((traffic == TR_SRC_IDLE && $urandom_range(0, 99) < 80) ||
				(traffic == TR_BOTH_IDLE && $urandom_range(0, 99) < 32))) begin
			req = pending_requests[req_head % REQ_DEPTH];
			req_head = req_head + 1;
			in_valid     <= 1'b1;
			client_index <= req.client;
			now_ms       <= req.stamp_ms;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Response sink: random stalls per traffic pattern, and a long hold-off
	// in the backlog pattern so the block fills and stops taking requests.
	always @(negedge clk) begin
		if (traffic == TR_BACKLOG && backlog_count < BACKLOG_CYCLES) begin
			out_ready     <= 1'b0;
			backlog_count <= backlog_count + 1;
		end else begin
			if (traffic != TR_BACKLOG)
				backlog_count <= 0;
			if (traffic == TR_SINK_STALL)
				out_ready <= ($urandom_range(0, 99) >= 80);
			else if (traffic == TR_BOTH_IDLE)
				out_ready <= ($urandom_range(0, 99) >= 32);
			else
				out_ready <= 1'b1;
		end
	end

	// Monitor: predict on each accepted request beat, check each response
	// beat against the oldest prediction, and watch for a hung block.
	always @(posedge clk) begin : check_responses
		logic want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_permits[exp_tail % REQ_DEPTH] = take_token(client_index, now_ms);
				exp_tail = exp_tail + 1;
			end
			if (out_valid && out_ready) begin
				if (exp_head == exp_tail) begin
					$error("permitted: response beat with no request waiting, actual %0b",
						permitted);
					fail_count++;
				end else begin
					want = expected_permits[exp_head % REQ_DEPTH];
					exp_head = exp_head + 1;
					if (permitted !== want) begin
						$error("permitted mismatch: expected %0b, actual %0b", want, permitted);
						fail_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("per_client_token_bucket_limiter_unit test failed");
				$finish;
			end
		end
	end

	// Stimulus: directed corner cases first, then random phases.
	initial begin : stimulus
		logic [NOW_BITS-1:0] clock_ms;
		logic [IDX_BITS-1:0] cl;
		int                  pick;

		for (int i = 0; i < NUM_BUCKETS; i++) begin
			bucket_live[i]   = 1'b0;
			bucket_tokens[i] = '0;
			bucket_stamp[i]  = '0;
		end
		cap_reg  = CAP_RESET;
		rate_reg = RATE_RESET;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain a fresh bucket, then under one second, one second, and a
		// time that runs backwards.
		repeat (4) queue_request(8'd0, 48'd0);
		queue_request(8'd0, 48'd999);
		queue_request(8'd0, 48'd1000);
		queue_request(8'd0, 48'd500);
		// Widest time, then back to zero.
		queue_request(8'd255, 48'hFFFF_FFFF_FFFF);
		queue_request(8'd255, 48'd0);
		// Gap far past the seconds saturation point.
		queue_request(8'd170, 48'h0100_0000_0000);
		queue_request(8'd170, 48'h0100_0000_0000 + 48'd500_000_000);
		queue_request(8'd85, 48'hAAAA_AAAA_AAAA);
		queue_request(8'd85, 48'h5555_5555_5555);
		wait_idle();

		// Largest settings, plus writes to the unused register slots.
		write_reg(CFG_CAPACITY, 16'hFFFF);
		write_reg(CFG_REFILL, 16'hFFFF);
		write_reg(CFG_SPARE_A, 16'h0000);
		write_reg(CFG_SPARE_B, 16'h5A5A);
		queue_request(8'd3, 48'd0);
		queue_request(8'd3, 48'd0);
		wait_idle();

		// Capacity lowered under a full bucket: the refill clamps it down.
		write_reg(CFG_CAPACITY, 16'd2);
		repeat (3) queue_request(8'd3, 48'd1000);
		wait_idle();

		// Zero capacity: new buckets start empty and stay empty.
		write_reg(CFG_CAPACITY, 16'd0);
		queue_request(8'd4, 48'd7);
		queue_request(8'd4, 48'd10_000);
		wait_idle();

		clock_ms = 48'd20_000;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			write_reg(CFG_CAPACITY, phase_cap[ph]);
			write_reg(CFG_REFILL, phase_rate[ph]);
			write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
				CFG_DATA_W'($urandom));
			if (ph % 3 == 2)
				clock_ms = 48'({$urandom, $urandom});
			case (ph % 5)
				0: traffic = TR_STEADY;
				1: traffic = TR_SRC_IDLE;
				2: traffic = TR_SINK_STALL;
				3: traffic = TR_BOTH_IDLE;
				default: traffic = TR_BACKLOG;
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Mostly a small set of clients so buckets get reused.
				if ($urandom_range(0, 99) < 70)
					cl = IDX_BITS'($urandom_range(0, 7));
				else
					cl = IDX_BITS'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					clock_ms = clock_ms + 48'($urandom_range(0, 1500));
					queue_request(cl, clock_ms);
				end else if (pick < 85) begin
					clock_ms = clock_ms + 48'($urandom_range(1500, 20_000));
					queue_request(cl, clock_ms);
				end else if (pick < 90) begin
					clock_ms = clock_ms + 48'($urandom_range(60_000_000, 400_000_000));
					queue_request(cl, clock_ms);
				end else if (pick < 98) begin
					queue_request(cl, clock_ms - 48'($urandom_range(1, 5000)));
				end else begin
					queue_request(cl, 48'({$urandom, $urandom}));
				end
			end
		end

		wait_idle();
		if (fail_count == 0 && exp_head == exp_tail)
			$display("per_client_token_bucket_limiter_unit test passed");
		else
			$display("per_client_token_bucket_limiter_unit test failed");
		$finish;
	end

endmodule
